// ===== sv/advertiser_scan_table_top_assert.svh =====
// Assertion macros for the advertiser scan table.
// Each check is clocked on clk and held off while rst_n is low.
`ifndef ADVERTISER_SCAN_TABLE_TOP_ASSERT_SVH
`define ADVERTISER_SCAN_TABLE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define ASCT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("advertiser scan table check failed");
// Next-cycle implication.
`define ASCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("advertiser scan table check failed");
`else
`define ASCT_ASSERT_IMPL(lbl, ante, cons)
`define ASCT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/asct_pkg.sv =====
package asct_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES   = 16;
    localparam int MAX_PAYLOAD_LEN = 31;
    localparam int CNT_W           = $clog2(TABLE_ENTRIES + 1);

    // Command codes
    localparam logic [1:0] FN_UPDATE = 2'd0;
    localparam logic [1:0] FN_READ   = 2'd1;
    localparam logic [1:0] FN_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        ST_UPDATED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_REJECTED  = 3'd3,
        ST_READ_HIT  = 3'd4,
        ST_READ_MISS = 3'd5,
        ST_CLEARED   = 3'd6
    } status_t;

    // Input word
    typedef struct packed {
        logic [1:0]        func;
        logic [1:0]        addr_type;
        logic [47:0]       address;
        logic [7:0]        pdu_type;
        logic signed [7:0] rssi;
        logic [1:0]        phy_primary;
        logic [1:0]        phy_secondary;
        logic [31:0]       timestamp;
        logic [7:0]        payload_length;
        logic [7:0]        position;
    } cmd_t;

    // Result word
    typedef struct packed {
        status_t           status;
        logic [1:0]        out_addr_type;
        logic [47:0]       out_address;
        logic [7:0]        out_pdu_type;
        logic signed [7:0] out_rssi;
        logic [1:0]        out_phy_primary;
        logic [1:0]        out_phy_secondary;
        logic [31:0]       first_seen;
        logic [31:0]       last_seen;
        logic [15:0]       message_count;
        logic [4:0]        out_payload_length;
    } result_t;

    // One table entry as held in a cell
    typedef struct packed {
        logic [1:0]        addr_type;
        logic [47:0]       address;
        logic [7:0]        pdu_type;
        logic signed [7:0] rssi;
        logic [1:0]        phy_primary;
        logic [1:0]        phy_secondary;
        logic [31:0]       first_seen;
        logic [31:0]       last_seen;
        logic [15:0]       message_count;
        logic [4:0]        payload_length;
    } entry_t;

    // Control from the top to one cell
    typedef struct packed {
        logic valid;   // entry is below the fill count
        logic rd_sel;  // read position points here
        logic ins;     // append new entry here
        logic upd;     // update pass is live
    } cell_ctl_t;

    // Link handed from one cell to the next
    typedef struct packed {
        logic   hit;   // some earlier cell matched the key
        entry_t entry; // read data collected so far
    } link_t;

endpackage

// ===== sv/advertiser_scan_table_top.sv =====
// Advertiser scan table: duplicate filter of seen advertisers.
// A command word is taken on cmd at a clock edge where start is high and
// busy is low. func selects update, read by position or clear.
// In the working cycle of a command, every cell of the row compares
// its held key with the command key and the match flag and the selected read
// entry ripple along the row; at the end of that cycle an update of legal
// length writes the hit cell or, if the table has room, the next free cell,
// and the result word is registered. done is high for exactly one cycle, the
// cycle after that, with the word on result; the receiver has to take it then.
// busy is high for the one working cycle, so a new command can be taken
// while done is high. Unused func code 3 runs the same way but raises no done.
// Result fields other than status are zero unless status is a read hit.
// Reset clears the fill count and the handshake; cell contents are left
// as they are and are never read until written again.
`include "advertiser_scan_table_top_assert.svh"

module advertiser_scan_table_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  asct_pkg::cmd_t    cmd,
    output logic              done,
    output asct_pkg::result_t result
);

    localparam int N = asct_pkg::TABLE_ENTRIES;
    localparam int W = asct_pkg::CNT_W;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [W-1:0]            count_reg, count_next;
    asct_pkg::cmd_t          cmd_reg;
    asct_pkg::result_t       result_reg, result_next;

    asct_pkg::link_t         link [0:N];
    asct_pkg::cell_ctl_t     ctl [0:N-1];
    logic [N-1:0]            hit_vec;
    asct_pkg::entry_t        new_entry;

    logic accept;
    logic upd_en;
    logic ins_en;
    logic len_bad;
    logic full;
    logic any_hit;
    logic rd_hit;

    assign accept  = start && !busy_reg;
    assign len_bad = cmd_reg.payload_length > 8'(asct_pkg::MAX_PAYLOAD_LEN);
    assign full    = count_reg == W'(N);
    assign any_hit = link[N].hit;
    assign upd_en  = busy_reg && (cmd_reg.func == asct_pkg::FN_UPDATE) && !len_bad;
    assign ins_en  = upd_en && !any_hit && !full;
    assign rd_hit  = {1'b0, cmd_reg.position} < 9'(count_reg);

    // Entry built for an append
    always_comb
    begin
        new_entry.addr_type      = cmd_reg.addr_type;
        new_entry.address        = cmd_reg.address;
        new_entry.pdu_type       = cmd_reg.pdu_type;
        new_entry.rssi           = cmd_reg.rssi;
        new_entry.phy_primary    = cmd_reg.phy_primary;
        new_entry.phy_secondary  = cmd_reg.phy_secondary;
        new_entry.first_seen     = cmd_reg.timestamp;
        new_entry.last_seen      = cmd_reg.timestamp;
        new_entry.message_count  = 16'd1;
        new_entry.payload_length = cmd_reg.payload_length[4:0];
    end

    assign link[0] = '0;

    // Row of cells
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        always_comb
        begin
            ctl[i].valid  = W'(i) < count_reg;
            ctl[i].rd_sel = cmd_reg.position == 8'(i);
            ctl[i].ins    = ins_en && (count_reg == W'(i));
            ctl[i].upd    = upd_en;
        end

        asct_cell u_cell (
            .clk        (clk),
            .ctl        (ctl[i]),
            .key_type   (cmd_reg.addr_type),
            .key_address(cmd_reg.address),
            .now        (cmd_reg.timestamp),
            .new_entry  (new_entry),
            .link_in    (link[i]),
            .link_out   (link[i+1]),
            .hit        (hit_vec[i])
        );
    end

    // Command decode and result
    always_comb
    begin
        result_next = '0;
        count_next  = count_reg;
        done_next   = 1'b0;
        busy_next   = busy_reg ? 1'b0 : accept;
        if (busy_reg)
        begin
            done_next = 1'b1;
            unique case (cmd_reg.func)
                asct_pkg::FN_CLEAR:
                begin
                    count_next         = '0;
                    result_next.status = asct_pkg::ST_CLEARED;
                end
                asct_pkg::FN_READ:
                begin
                    if (rd_hit)
                    begin
                        result_next.status             = asct_pkg::ST_READ_HIT;
                        result_next.out_addr_type      = link[N].entry.addr_type;
                        result_next.out_address        = link[N].entry.address;
                        result_next.out_pdu_type       = link[N].entry.pdu_type;
                        result_next.out_rssi           = link[N].entry.rssi;
                        result_next.out_phy_primary    = link[N].entry.phy_primary;
                        result_next.out_phy_secondary  = link[N].entry.phy_secondary;
                        result_next.first_seen         = link[N].entry.first_seen;
                        result_next.last_seen          = link[N].entry.last_seen;
                        result_next.message_count      = link[N].entry.message_count;
                        result_next.out_payload_length = link[N].entry.payload_length;
                    end
                    else
                    begin
                        result_next.status = asct_pkg::ST_READ_MISS;
                    end
                end
                asct_pkg::FN_UPDATE:
                begin
                    if (len_bad)
                    begin
                        result_next.status = asct_pkg::ST_REJECTED;
                    end
                    else if (any_hit)
                    begin
                        result_next.status = asct_pkg::ST_UPDATED;
                    end
                    else if (full)
                    begin
                        result_next.status = asct_pkg::ST_DROPPED;
                    end
                    else
                    begin
                        result_next.status = asct_pkg::ST_INSERTED;
                        count_next         = count_reg + W'(1);
                    end
                end
                default:
                begin
                    done_next = 1'b0;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        result_reg <= result_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    // Checks
    `ASCT_ASSERT_NEXT(a_busy_one_cycle, busy_reg, !busy_reg)
    `ASCT_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= W'(N))
    `ASCT_ASSERT_IMPL(a_single_match, 1'b1, $onehot0(hit_vec))
    `ASCT_ASSERT_IMPL(a_insert_counts, done_reg && result_reg.status == asct_pkg::ST_INSERTED, count_reg != '0)

endmodule

// ===== sv/asct_cell.sv =====
module asct_cell (
    input  logic              clk,
    input  asct_pkg::cell_ctl_t ctl,
    input  logic [1:0]        key_type,
    input  logic [47:0]       key_address,
    input  logic [31:0]       now,
    input  asct_pkg::entry_t  new_entry,
    input  asct_pkg::link_t   link_in,
    output asct_pkg::link_t   link_out,
    output logic              hit
);

    asct_pkg::entry_t entry_reg;
    asct_pkg::entry_t entry_next;

    // Key match against the held entry
    assign hit = ctl.valid && (entry_reg.addr_type == key_type)
                 && (entry_reg.address == key_address);

    // Pass match flag and read data along the row
    always_comb
    begin
        link_out.hit   = link_in.hit | hit;
        link_out.entry = ctl.rd_sel ? (link_in.entry | entry_reg) : link_in.entry;
    end

    // Append or refresh
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins)
        begin
            entry_next = new_entry;
        end
        else if (ctl.upd && hit)
        begin
            if (entry_reg.message_count != 16'hFFFF)
            begin
                entry_next.message_count = entry_reg.message_count + 16'd1;
            end
            entry_next.last_seen = now;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
